>>> rtl/bfe_pkg.sv
// Book fill estimator package: widths, opcodes, divide-by-100 constants and
// the lane tag that travels with each book level down the walk pipeline.
// No dependencies.
package bfe_pkg;

    localparam int LEVELS_DEF = 5;

    localparam int OPC_W   = 1;
    localparam int SIDE_W  = 2;
    localparam int LEVEL_W = 3;
    localparam int PRICE_W = 24;
    localparam int QTY_W   = 31;
    localparam int AMT_W   = 55;
    localparam int PCT_W   = 7;
    localparam int FILL_W  = 32;

    localparam logic [PCT_W-1:0] PCT_RESET = 7'd20;

    localparam logic [OPC_W-1:0]  OP_LOAD  = 1'b0;
    localparam logic [OPC_W-1:0]  OP_MATCH = 1'b1;
    localparam logic [SIDE_W-1:0] SIDE_ASK = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_BID = 2'd1;

    // volume / 100 : floor(vol * DIV_A_MAGIC / 2^DIV_A_SHIFT), exact for 31-bit vol
    localparam int               A_W         = 25;
    localparam int               DIV_A_W     = 32;
    localparam logic [DIV_A_W-1:0] DIV_A_MAGIC = 32'd2748779070;
    localparam int               DIV_A_SHIFT = 38;

    // remainder part: (rem * pct) / 100, exact for 14-bit products
    localparam int               REM_W       = 7;
    localparam int               BP_W        = 14;
    localparam int               DIV_B_W     = 15;
    localparam logic [DIV_B_W-1:0] DIV_B_MAGIC = 15'd20972;
    localparam int               DIV_B_SHIFT = 21;

    typedef struct packed {
        logic valid;
        logic last;
    } lane_t;

endpackage

>>> rtl/bfe_book_mem.sv
// Book storage: ask and bid levels, price and volume per entry, one write and
// one registered read per cycle; per-entry valid bits give the zero reset.
// Depends on bfe_pkg.
module bfe_book_mem
    import bfe_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [$clog2(2*LEVELS)-1:0]       wr_addr,
    input  logic [PRICE_W-1:0]                wr_price,
    input  logic [QTY_W-1:0]                  wr_volume,
    input  logic                              rd_en,
    input  logic [$clog2(2*LEVELS)-1:0]       rd_addr,
    output logic [PRICE_W-1:0]                rd_price,
    output logic [QTY_W-1:0]                  rd_volume
);

    localparam int DEPTH = 2 * LEVELS;

    logic [PRICE_W+QTY_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]         valid_reg;
    logic [PRICE_W+QTY_W-1:0] rd_data_reg;
    logic                     rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_price, wr_volume};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_price  = rd_hit_reg ? rd_data_reg[QTY_W +: PRICE_W] : '0;
    assign rd_volume = rd_hit_reg ? rd_data_reg[QTY_W-1:0]        : '0;

endmodule

>>> rtl/bfe_level_fill.sv
// Per-level fill pipeline: price test and floor(volume * pct / 100) in four
// registered stages (reciprocal multiplies, no divider).
// Depends on bfe_pkg.
module bfe_level_fill
    import bfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lane_t               lane_in,
    input  logic [PRICE_W-1:0]  price_in,
    input  logic [QTY_W-1:0]    volume_in,
    input  logic [PRICE_W-1:0]  limit,
    input  logic                is_bid,
    input  logic [PCT_W-1:0]    pct,
    output lane_t               lane_out,
    output logic [PRICE_W-1:0]  price_out,
    output logic                pass_out,
    output logic [FILL_W-1:0]   fill_out
);

    lane_t               s1_lane_reg, s2_lane_reg, s3_lane_reg, s4_lane_reg;
    logic [PRICE_W-1:0]  s1_price_reg, s2_price_reg, s3_price_reg, s4_price_reg;
    logic                s1_pass_reg, s2_pass_reg, s3_pass_reg, s4_pass_reg;
    logic [QTY_W-1:0]    s1_vol_reg;
    logic [A_W-1:0]      s1_a_reg;
    logic [FILL_W-1:0]   s2_ap_reg, s3_ap_reg, s4_fill_reg;
    logic [REM_W-1:0]    s2_b_reg;
    logic [BP_W-1:0]     s3_bp_reg;

    logic [QTY_W+DIV_A_W-1:0]  prod_a;
    logic                      pass_c;
    logic [QTY_W-1:0]          hund_c;
    logic [QTY_W-1:0]          rem_c;
    logic [BP_W+DIV_B_W-1:0]   prod_b;

    always_comb
    begin
        prod_a = (QTY_W+DIV_A_W)'(volume_in) * (QTY_W+DIV_A_W)'(DIV_A_MAGIC);
        if (is_bid)
        begin
            pass_c = (price_in >= limit) && (limit != '0);
        end
        else
        begin
            pass_c = (price_in != '0) && (price_in <= limit);
        end
        hund_c = QTY_W'(s1_a_reg) * QTY_W'(100);
        rem_c  = s1_vol_reg - hund_c;
        prod_b = (BP_W+DIV_B_W)'(s3_bp_reg) * (BP_W+DIV_B_W)'(DIV_B_MAGIC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_lane_reg <= '0;
            s2_lane_reg <= '0;
            s3_lane_reg <= '0;
            s4_lane_reg <= '0;
        end
        else
        begin
            s1_lane_reg <= lane_in;
            s2_lane_reg <= s1_lane_reg;
            s3_lane_reg <= s2_lane_reg;
            s4_lane_reg <= s3_lane_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_price_reg <= price_in;
        s1_pass_reg  <= pass_c;
        s1_vol_reg   <= volume_in;
        s1_a_reg     <= prod_a[DIV_A_SHIFT +: A_W];

        s2_price_reg <= s1_price_reg;
        s2_pass_reg  <= s1_pass_reg;
        s2_ap_reg    <= FILL_W'(s1_a_reg) * FILL_W'(pct);
        s2_b_reg     <= rem_c[REM_W-1:0];

        s3_price_reg <= s2_price_reg;
        s3_pass_reg  <= s2_pass_reg;
        s3_ap_reg    <= s2_ap_reg;
        s3_bp_reg    <= BP_W'(s2_b_reg) * BP_W'(pct);

        s4_price_reg <= s3_price_reg;
        s4_pass_reg  <= s3_pass_reg;
        s4_fill_reg  <= s3_ap_reg + FILL_W'(prod_b[DIV_B_SHIFT +: REM_W]);
    end

    assign lane_out  = s4_lane_reg;
    assign price_out = s4_price_reg;
    assign pass_out  = s4_pass_reg;
    assign fill_out  = s4_fill_reg;

endmodule

>>> rtl/bfe_accum.sv
// Walk accumulator: clips each level's fill to what is still wanted, stops at
// the first failing level or when the wanted quantity is reached, sums amount.
// Depends on bfe_pkg.
module bfe_accum
    import bfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic [QTY_W-1:0]    want_qty,
    input  lane_t               lane_in,
    input  logic [PRICE_W-1:0]  price_in,
    input  logic                pass_in,
    input  logic [FILL_W-1:0]   fill_in,
    output logic                done,
    output logic [QTY_W-1:0]    sum_qty,
    output logic [AMT_W-1:0]    sum_amt
);

    logic                stop_reg, stop_next;
    logic [QTY_W-1:0]    sum_reg, sum_next;
    lane_t               e_lane_reg, m_lane_reg;
    logic [PRICE_W-1:0]  e_price_reg;
    logic [FILL_W-1:0]   e_eff_reg, eff_next;
    logic [AMT_W-1:0]    m_prod_reg;
    logic [AMT_W-1:0]    amt_reg;
    logic                done_reg;
    logic [QTY_W-1:0]    rem;
    logic [PRICE_W+FILL_W-1:0] prod;

    always_comb
    begin
        rem       = want_qty - sum_reg;
        stop_next = stop_reg;
        sum_next  = sum_reg;
        eff_next  = '0;
        if (lane_in.valid && !stop_reg)
        begin
            if (!pass_in)
            begin
                stop_next = 1'b1;
            end
            else if (fill_in >= FILL_W'(rem))
            begin
                eff_next  = FILL_W'(rem);
                sum_next  = want_qty;
                stop_next = 1'b1;
            end
            else
            begin
                eff_next = fill_in;
                sum_next = sum_reg + fill_in[QTY_W-1:0];
            end
        end
        prod = (PRICE_W+FILL_W)'(e_price_reg) * (PRICE_W+FILL_W)'(e_eff_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg   <= 1'b0;
            sum_reg    <= '0;
            amt_reg    <= '0;
            e_lane_reg <= '0;
            m_lane_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            e_lane_reg <= lane_in;
            m_lane_reg <= e_lane_reg;
            done_reg   <= m_lane_reg.valid && m_lane_reg.last;
            if (clear)
            begin
                stop_reg <= 1'b0;
                sum_reg  <= '0;
                amt_reg  <= '0;
            end
            else
            begin
                stop_reg <= stop_next;
                sum_reg  <= sum_next;
                if (m_lane_reg.valid)
                begin
                    amt_reg <= amt_reg + m_prod_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_price_reg <= price_in;
        e_eff_reg   <= eff_next;
        m_prod_reg  <= prod[AMT_W-1:0];
    end

    assign done    = done_reg;
    assign sum_qty = sum_reg;
    assign sum_amt = amt_reg;

endmodule

>>> rtl/book_fill_estimator_core.sv
// Book fill estimator top level: input/output channels, walk sequencer,
// fill_percent register and output register.
// Depends on bfe_pkg, bfe_book_mem, bfe_level_fill, bfe_accum.
//
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, side, level, price and
//   amount_qty. A load transaction writes one book level in the accept cycle
//   and produces no result; in_ready stays high, so loads run one per cycle.
//   A match transaction produces one result (filled_qty, filled_amount) on
//   the output channel (out_valid/out_ready).
//   A match walks the book through the memory read port, which issues one
//   level per cycle, then through the fill and multiply-accumulate
//   pipelines to out_valid. Side 2 or 3 matches skip the walk and return
//   zeros. in_ready is low after a match is accepted until its result is
//   loaded into the output register. The result sits in an output register;
//   the next transaction is accepted while it waits. If the receiver stalls
//   and a new match finishes, that match holds in its last state until the
//   output register frees up. The user must write fill_percent through
//   cfg_we/cfg_wdata only while idle; the block does not enforce it. Reset
//   clears the book (all levels price 0, volume 0), sets fill_percent to 20
//   and empties the output register; no clearing pass is needed.
module book_fill_estimator_core
    import bfe_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [PCT_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OPC_W-1:0]    opcode,
    input  logic [SIDE_W-1:0]   side,
    input  logic [LEVEL_W-1:0]  level,
    input  logic [PRICE_W-1:0]  price,
    input  logic [QTY_W-1:0]    amount_qty,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [QTY_W-1:0]    filled_qty,
    output logic [AMT_W-1:0]    filled_amount
);

    localparam int AW    = $clog2(2 * LEVELS);
    localparam int CNT_W = $clog2(LEVELS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PCT_W-1:0]    pct_reg;
    logic [PRICE_W-1:0]  limit_reg;
    logic [QTY_W-1:0]    want_reg;
    logic                is_bid_reg;
    lane_t               issue_lane, rd_lane_reg;
    logic                out_valid_reg;
    logic [QTY_W-1:0]    filled_qty_reg;
    logic [AMT_W-1:0]    filled_amount_reg;

    logic                accept, match_acc, side_ok, wr_en, rd_en, clear, load_out;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [PRICE_W-1:0]  mem_price;
    logic [QTY_W-1:0]    mem_volume;
    lane_t               fill_lane;
    logic [PRICE_W-1:0]  fill_price;
    logic                fill_pass;
    logic [FILL_W-1:0]   fill_val;
    logic                acc_done;
    logic [QTY_W-1:0]    acc_qty;
    logic [AMT_W-1:0]    acc_amt;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign side_ok   = (side == SIDE_ASK) || (side == SIDE_BID);
    assign match_acc = accept && (opcode == OP_MATCH);
    assign clear     = match_acc;
    assign wr_en     = accept && (opcode == OP_LOAD) && side_ok && (32'(level) < LEVELS);
    assign wr_addr   = (side == SIDE_BID ? AW'(LEVELS) : AW'(0)) + AW'(level);
    assign rd_en     = (state_reg == ST_ISSUE);
    assign rd_addr   = (is_bid_reg ? AW'(LEVELS) : AW'(0)) + AW'(cnt_reg);
    assign load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        issue_lane.valid = rd_en;
        issue_lane.last  = rd_en && (cnt_reg == CNT_W'(LEVELS - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (match_acc)
                begin
                    state_next = side_ok ? ST_ISSUE : ST_FINISH;
                end
            end
            ST_ISSUE:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (issue_lane.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (acc_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pct_reg       <= PCT_RESET;
            rd_lane_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_lane_reg <= issue_lane;
            if (cfg_we)
            begin
                pct_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (match_acc)
        begin
            limit_reg  <= price;
            want_reg   <= amount_qty;
            is_bid_reg <= (side == SIDE_BID);
        end
        if (load_out)
        begin
            filled_qty_reg    <= acc_qty;
            filled_amount_reg <= acc_amt;
        end
    end

    bfe_book_mem #(
        .LEVELS (LEVELS)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_price  (price),
        .wr_volume (amount_qty),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_price  (mem_price),
        .rd_volume (mem_volume)
    );

    bfe_level_fill u_fill (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_in   (rd_lane_reg),
        .price_in  (mem_price),
        .volume_in (mem_volume),
        .limit     (limit_reg),
        .is_bid    (is_bid_reg),
        .pct       (pct_reg),
        .lane_out  (fill_lane),
        .price_out (fill_price),
        .pass_out  (fill_pass),
        .fill_out  (fill_val)
    );

    bfe_accum u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (clear),
        .want_qty (want_reg),
        .lane_in  (fill_lane),
        .price_in (fill_price),
        .pass_in  (fill_pass),
        .fill_in  (fill_val),
        .done     (acc_done),
        .sum_qty  (acc_qty),
        .sum_amt  (acc_amt)
    );

    assign out_valid     = out_valid_reg;
    assign filled_qty    = filled_qty_reg;
    assign filled_amount = filled_amount_reg;

endmodule

>>> rtl/bfe_checker.sv
// Port-level checker for book_fill_estimator_core, attached by bind.
// Depends on bfe_pkg and the top level's port list.
module bfe_checker
    import bfe_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_we,
    input logic [PCT_W-1:0]    cfg_wdata,
    input logic                in_valid,
    input logic                in_ready,
    input logic [OPC_W-1:0]    opcode,
    input logic [SIDE_W-1:0]   side,
    input logic [LEVEL_W-1:0]  level,
    input logic [PRICE_W-1:0]  price,
    input logic [QTY_W-1:0]    amount_qty,
    input logic                out_valid,
    input logic                out_ready,
    input logic [QTY_W-1:0]    filled_qty,
    input logic [AMT_W-1:0]    filled_amount
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filled_qty)
            && $stable(filled_amount))
        else $error("result changed while stalled");

    a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_LOAD) |=> in_ready)
        else $error("load transaction blocked the input channel");

    a_match_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_MATCH) |=> !in_ready)
        else $error("match transaction did not hold off input");

    a_both_sides_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_MATCH) && side[1] && !out_valid
            |-> ##2 out_valid && (filled_qty == '0) && (filled_amount == '0))
        else $error("side-both match did not return zeros");

    a_zero_qty_zero_amt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (filled_qty == '0) |-> (filled_amount == '0))
        else $error("amount without filled quantity");

endmodule

bind book_fill_estimator_core bfe_checker u_bfe_checker (.*);

>>> tb/tb_book_fill_estimator_core.sv
// Testbench for book_fill_estimator_core: drives load and match transactions,
// predicts each match result from a local copy of the book and checks it.
// Depends on bfe_pkg and book_fill_estimator_core.
`timescale 1ns / 100ps

module tb_book_fill_estimator_core;
    import bfe_pkg::*;

    localparam int LEVELS = LEVELS_DEF;
    localparam int N_PHASES = 12;
    localparam int PHASE_ITEMS = 160;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [QTY_W-1:0] qty;
        logic [AMT_W-1:0] amt;
    } fill_result_t;

    class fill_scoreboard;
        logic [PRICE_W-1:0] lvl_price [2*LEVELS];
        logic [QTY_W-1:0]   lvl_volume [2*LEVELS];
        logic [PCT_W-1:0]   pct;
        fill_result_t       expected_fills [$];
        int unsigned        errors;

        function new();
            int i;
            for (i = 0; i < 2*LEVELS; i++)
            begin
                lvl_price[i] = '0;
                lvl_volume[i] = '0;
            end
            pct = PCT_RESET;
            errors = 0;
        endfunction

        function void set_pct(logic [PCT_W-1:0] v);
            pct = v;
        endfunction

        function int pending();
            return expected_fills.size();
        endfunction

        function void note_input(logic [OPC_W-1:0] opc, logic [SIDE_W-1:0] sd,
                                 logic [LEVEL_W-1:0] lv, logic [PRICE_W-1:0] px,
                                 logic [QTY_W-1:0] q);
            fill_result_t r;
            logic [63:0]  run_qty, run_amt, fill, p, lim, want;
            int           base, i;
            bit           stop, pass;
            base = (sd == SIDE_BID) ? LEVELS : 0;
            if (opc == OP_LOAD)
            begin
                if ((sd == SIDE_ASK || sd == SIDE_BID) && lv < LEVELS)
                begin
                    lvl_price[base + lv] = px;
                    lvl_volume[base + lv] = q;
                end
                return;
            end
            run_qty = '0;
            run_amt = '0;
            lim = 64'(px);
            want = 64'(q);
            stop = 1'b0;
            if (sd == SIDE_ASK || sd == SIDE_BID)
            begin
                for (i = 0; i < LEVELS && !stop; i++)
                begin
                    p = 64'(lvl_price[base + i]);
                    if (sd == SIDE_BID)
                        pass = (p >= lim) && (lim != 0);
                    else
                        pass = (p != 0) && (p <= lim);
                    if (!pass)
                        stop = 1'b1;
                    else
                    begin
                        fill = 64'(lvl_volume[base + i]) * 64'(pct) / 64'd100;
                        run_qty += fill;
                        run_amt += p * fill;
                        if (run_qty >= want)
                        begin
                            run_amt -= p * (run_qty - want);
                            run_qty = want;
                            stop = 1'b1;
                        end
                    end
                end
            end
            r.qty = run_qty[QTY_W-1:0];
            r.amt = run_amt[AMT_W-1:0];
            expected_fills.push_back(r);
        endfunction

        function void check_result(logic [QTY_W-1:0] q, logic [AMT_W-1:0] a);
            fill_result_t e;
            if (expected_fills.size() == 0)
            begin
                $error("unexpected result: filled_qty %0d filled_amount %0d", q, a);
                errors++;
                return;
            end
            e = expected_fills.pop_front();
            if (q !== e.qty)
            begin
                $error("filled_qty: expected %0d, actual %0d", e.qty, q);
                errors++;
            end
            if (a !== e.amt)
            begin
                $error("filled_amount: expected %0d, actual %0d", e.amt, a);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [PCT_W-1:0]    cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OPC_W-1:0]    opcode = '0;
    logic [SIDE_W-1:0]   side = '0;
    logic [LEVEL_W-1:0]  level = '0;
    logic [PRICE_W-1:0]  price = '0;
    logic [QTY_W-1:0]    amount_qty = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [QTY_W-1:0]    filled_qty;
    logic [AMT_W-1:0]    filled_amount;

    fill_scoreboard sb = new();

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int px_shift = 0;
    bit hold_req = 1'b0;
    int hold_len = 0;

    book_fill_estimator_core #(.LEVELS(LEVELS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .side          (side),
        .level         (level),
        .price         (price),
        .amount_qty    (amount_qty),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .filled_qty    (filled_qty),
        .filled_amount (filled_amount)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_pct(cfg_wdata);
            if (out_valid && out_ready)
                sb.check_result(filled_qty, filled_amount);
            if (in_valid && in_ready)
                sb.note_input(opcode, side, level, price, amount_qty);
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    task automatic send_txn(input logic [OPC_W-1:0] opc, input logic [SIDE_W-1:0] sd,
                            input logic [LEVEL_W-1:0] lv, input logic [PRICE_W-1:0] px,
                            input logic [QTY_W-1:0] q);
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < snd_idle_pct);
        end
        in_valid <= 1'b1;
        opcode <= opc;
        side <= sd;
        level <= lv;
        price <= px;
        amount_qty <= q;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_fill_pct(input logic [PCT_W-1:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PRICE_W-1:0] pick_book_price(logic [SIDE_W-1:0] sd,
                                                           logic [LEVEL_W-1:0] lv);
        int unsigned r, base;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        if (r < 20)
            return PRICE_W'($urandom);
        if (sd == SIDE_ASK)
            base = 1000 + lv * 1000 + $urandom_range(0, 999);
        else
            base = 6000 - lv * 1000 - $urandom_range(0, 999);
        return PRICE_W'(base << px_shift);
    endfunction

    function automatic logic [PRICE_W-1:0] pick_limit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 15)
            return '1;
        if (r < 25)
            return PRICE_W'($urandom);
        return PRICE_W'($urandom_range(0, 7000) << px_shift);
    endfunction

    function automatic logic [QTY_W-1:0] pick_volume();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '1;
        if (r < 20)
            return QTY_W'($urandom);
        if (r < 40)
            return QTY_W'($urandom_range(0, 1000000));
        return QTY_W'($urandom_range(0, 1000));
    endfunction

    function automatic logic [QTY_W-1:0] pick_qty();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 12)
            return '1;
        if (r < 25)
            return QTY_W'($urandom);
        if (r < 40)
            return QTY_W'($urandom_range(0, 300000));
        return QTY_W'($urandom_range(0, 600));
    endfunction

    task automatic send_random_item(output bit counted);
        int unsigned       r;
        logic [SIDE_W-1:0] sd;
        logic [LEVEL_W-1:0] lv;
        r = $urandom_range(0, 99);
        sd = SIDE_W'($urandom_range(0, 1));
        lv = LEVEL_W'($urandom_range(0, LEVELS - 1));
        counted = 1'b1;
        if (r < 32)
            send_txn(OP_LOAD, sd, lv, pick_book_price(sd, lv), pick_volume());
        else if (r < 87)
            send_txn(OP_MATCH, sd, LEVEL_W'($urandom_range(0, 7)), pick_limit(), pick_qty());
        else if (r < 93)
            send_txn(OP_MATCH, SIDE_W'($urandom_range(2, 3)), LEVEL_W'($urandom_range(0, 7)),
                     PRICE_W'($urandom), QTY_W'($urandom));
        else
        begin
            // load the block drops: bad side or level out of range
            counted = 1'b0;
            if ($urandom_range(0, 1))
                sd = SIDE_W'($urandom_range(2, 3));
            else
                lv = LEVEL_W'($urandom_range(LEVELS, 7));
            send_txn(OP_LOAD, sd, lv, PRICE_W'($urandom), QTY_W'($urandom));
        end
    endtask

    initial
    begin
        int         ph, n;
        bit         counted;
        logic [PCT_W-1:0] phase_pct [N_PHASES];
        phase_pct = '{7'd20, 7'd100, 7'd0, 7'd1, 7'd127, 7'd50, 7'd99, 7'd33,
                      7'd0, 7'd0, 7'd0, 7'd100};
        for (ph = 8; ph < 11; ph++)
            phase_pct[ph] = PCT_W'($urandom_range(0, 127));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty book, extremes, dropped loads, zero-result sides
        send_txn(OP_MATCH, SIDE_ASK, 3'd0, '1, '1);
        send_txn(OP_MATCH, SIDE_BID, 3'd0, '1, '1);
        send_txn(OP_LOAD, SIDE_ASK, 3'd0, 24'd1, 31'd100);
        send_txn(OP_LOAD, SIDE_ASK, 3'd1, 24'd500, 31'd1000);
        send_txn(OP_LOAD, SIDE_ASK, 3'd2, 24'd900, '1);
        send_txn(OP_LOAD, SIDE_ASK, 3'd3, '1, 31'd50);
        send_txn(OP_LOAD, SIDE_ASK, 3'd4, '1, '1);
        send_txn(OP_LOAD, SIDE_BID, 3'd0, '1, '1);
        send_txn(OP_LOAD, SIDE_BID, 3'd1, 24'd1000, 31'd999);
        send_txn(OP_LOAD, SIDE_BID, 3'd2, '0, 31'd7);
        send_txn(OP_LOAD, 2'd2, 3'd0, '1, '1);
        send_txn(OP_LOAD, 2'd3, 3'd1, '1, '1);
        send_txn(OP_LOAD, SIDE_ASK, 3'd5, 24'd2, 31'd5);
        send_txn(OP_LOAD, SIDE_BID, 3'd7, 24'd2, 31'd5);
        send_txn(OP_MATCH, SIDE_ASK, 3'd0, '1, '1);
        send_txn(OP_MATCH, SIDE_ASK, 3'd0, 24'd600, 31'd100);
        send_txn(OP_MATCH, SIDE_ASK, 3'd0, '0, 31'd5);
        send_txn(OP_MATCH, SIDE_ASK, 3'd0, 24'd1, '0);
        send_txn(OP_MATCH, SIDE_BID, 3'd7, 24'd1000, '1);
        send_txn(OP_MATCH, SIDE_BID, 3'd0, '1, 31'd1);
        send_txn(OP_MATCH, SIDE_BID, 3'd0, '0, '1);
        send_txn(OP_MATCH, 2'd2, 3'd0, '1, '1);
        send_txn(OP_MATCH, 2'd3, 3'd7, '1, '1);
        write_fill_pct(7'd127);
        send_txn(OP_MATCH, SIDE_ASK, 3'd0, '1, '1);
        write_fill_pct(7'd0);
        send_txn(OP_MATCH, SIDE_BID, 3'd0, 24'd1, '1);

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            write_fill_pct(phase_pct[ph]);
            case (ph % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 64; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 64; end
                default: begin snd_idle_pct = 10; rcv_stall_pct = 10; end
            endcase
            px_shift = $urandom_range(0, 11);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if (ph == 0 && n == 60)
                begin
                    hold_len = 400;
                    hold_req = 1'b1;
                end
                if (ph == 0 && n == 120)
                    wait_drained();
                send_random_item(counted);
                if (counted)
                    n++;
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
